/* rtl/utf8_pkg.sv */
`default_nettype none

package utf8_pkg;

    localparam int CP_W        = 21;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    // direction register codes
    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    // run length minus one
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // one unit of work for the back end
    typedef struct packed {
        logic [CP_W-1:0] value;  // code point (to encode, or decoded)
        logic [1:0]      len_m1; // bytes in the run minus one
        logic            enc;    // emit UTF-8 bytes rather than the value itself
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage

`default_nettype wire

/* rtl/utf8_in_if.sv */
`default_nettype none

interface utf8_in_if;
    logic                         valid;
    logic                         ready;
    logic [utf8_pkg::CP_W-1:0]    data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);
endinterface

`default_nettype wire

/* rtl/utf8_out_if.sv */
`default_nettype none

interface utf8_out_if;
    logic                         valid;
    logic                         ready;
    logic [utf8_pkg::CP_W-1:0]    data_out;
    logic                         last;

    modport source (output valid, output data_out, output last, input ready);
    modport sink   (input valid, input data_out, input last, output ready);
endinterface

`default_nettype wire

/* rtl/utf8_cfg_if.sv */
`default_nettype none

interface utf8_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

`default_nettype wire

/* rtl/utf8_front.sv */
`default_nettype none

module utf8_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    utf8_in_if.sink         i_in,
    utf8_cfg_if.sink        i_cfg,
    input  wire             i_full,
    output utf8_pkg::t_push o_push
);
    import utf8_pkg::*;

    logic            r_dir;
    logic [CP_W-1:0] r_accum, n_accum;
    logic [1:0]      r_left, n_left;

    logic            in_fire;
    logic [7:0]      b;
    logic [CP_W-1:0] shifted;
    logic [1:0]      len_m1;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign in_fire     = i_in.valid && !i_full;
    assign b           = i_in.data_in[BYTE_W-1:0];
    assign shifted     = {r_accum[CP_W-7:0], b[5:0]};

    // classify a code point by run length
    always_comb begin
        priority if (i_in.data_in[CP_W-1:7] == '0) begin
            len_m1 = LEN_1;
        end else if (i_in.data_in[CP_W-1:11] == '0) begin
            len_m1 = LEN_2;
        end else if (i_in.data_in[CP_W-1:16] == '0) begin
            len_m1 = LEN_3;
        end else begin
            len_m1 = LEN_4;
        end
    end

    always_comb begin
        n_accum    = r_accum;
        n_left     = r_left;
        o_push     = '0;
        o_push.job.value  = i_in.data_in;
        o_push.job.len_m1 = len_m1;
        o_push.job.enc    = 1'b1;
        if (in_fire) begin
            if (r_dir == DIR_ENCODE) begin
                o_push.valid = 1'b1;
            end else begin
                o_push.job.enc    = 1'b0;
                o_push.job.len_m1 = LEN_1;
                if (r_left == 2'd0) begin
                    priority if (b[7] == 1'b0) begin
                        o_push.valid     = 1'b1;
                        o_push.job.value = {{(CP_W-BYTE_W){1'b0}}, b};
                    end else if (b[7:5] == 3'b110) begin
                        n_accum = {{(CP_W-5){1'b0}}, b[4:0]};
                        n_left  = 2'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        n_accum = {{(CP_W-4){1'b0}}, b[3:0]};
                        n_left  = 2'd2;
                    end else begin
                        n_accum = {{(CP_W-3){1'b0}}, b[2:0]};
                        n_left  = 2'd3;
                    end
                end else begin
                    n_accum = shifted;
                    n_left  = r_left - 2'd1;
                    if (r_left == 2'd1) begin
                        o_push.valid     = 1'b1;
                        o_push.job.value = shifted;
                    end
                end
            end
        end
        // a direction write drops any partial sequence
        if (i_cfg.valid) begin
            n_accum = '0;
            n_left  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_DECODE;
            r_accum <= '0;
            r_left  <= 2'd0;
        end else begin
            r_accum <= n_accum;
            r_left  <= n_left;
            if (i_cfg.valid) begin
                r_dir <= i_cfg.direction;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/utf8_queue.sv */
`default_nettype none

module utf8_queue #(
    parameter int DEPTH = utf8_pkg::QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire utf8_pkg::t_push i_push,
    input  wire                  i_pop,
    output logic                 o_full,
    output utf8_pkg::t_head      o_head
);
    import utf8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            unique case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (!o_full || i_pop))
        else $error("push into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/utf8_back.sv */
`default_nettype none

module utf8_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire utf8_pkg::t_head i_head,
    output logic                 o_pop,
    utf8_out_if.source           o_out
);
    import utf8_pkg::*;

    logic [1:0]        r_idx;
    logic [1:0]        rem;
    logic [BYTE_W-1:0] enc_byte;
    logic              out_fire;
    logic [CP_W-1:0]   cp;

    assign cp  = i_head.job.value;
    assign rem = i_head.job.len_m1 - r_idx;

    // pick the lead or a continuation byte of the run
    always_comb begin
        if (r_idx == 2'd0) begin
            unique case (i_head.job.len_m1)
                LEN_1:   enc_byte = {1'b0, cp[6:0]};
                LEN_2:   enc_byte = {3'b110, cp[10:6]};
                LEN_3:   enc_byte = {4'b1110, cp[15:12]};
                default: enc_byte = {5'b11110, cp[20:18]};
            endcase
        end else begin
            unique case (rem)
                2'd0:    enc_byte = {2'b10, cp[5:0]};
                2'd1:    enc_byte = {2'b10, cp[11:6]};
                default: enc_byte = {2'b10, cp[17:12]};
            endcase
        end
    end

    assign o_out.valid    = i_head.valid;
    assign o_out.data_out = i_head.job.enc ? {{(CP_W-BYTE_W){1'b0}}, enc_byte} : cp;
    assign o_out.last     = !i_head.job.enc || (r_idx == i_head.job.len_m1);
    assign out_fire       = o_out.valid && o_out.ready;
    assign o_pop          = out_fire && o_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (out_fire) begin
            r_idx <= o_out.last ? 2'd0 : r_idx + 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> (i_head.valid && i_head.job.enc && r_idx <= i_head.job.len_m1))
        else $error("byte index outside an encode run");

    a_decode_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !i_head.job.enc) |-> o_out.last)
        else $error("decoded code point not marked last");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=>
            (o_out.valid && $stable(o_out.data_out) && $stable(o_out.last)))
        else $error("output changed while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/utf8_transcoder.sv */
`default_nettype none

// Channel  Dir  Payload                     Transfer when
// i_in     in   data_in[20:0]               i_in.valid && i_in.ready
// o_out    out  data_out[20:0], last        o_out.valid && o_out.ready
// i_cfg    in   direction                   i_cfg.valid && i_cfg.ready (always ready)
//
// Rate: decode takes one byte per cycle while the queue has room; encode emits
// one byte per cycle while o_out is ready, so a code point gives 1 to 4 bytes,
// set by the back end that walks the run one byte at a time.
// Latency: a result reaches o_out the cycle after its transfer if the queue was empty.
// Reset: synchronous, active low; direction goes to decode and the queue empties.
// Stalls: a QUEUE_DEPTH-entry queue separates input and output, so input keeps
// flowing while o_out is held until the queue fills.

module utf8_transcoder #(
    parameter int QUEUE_DEPTH = utf8_pkg::QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    utf8_in_if.sink    i_in,
    utf8_cfg_if.sink   i_cfg,
    utf8_out_if.source o_out
);
    import utf8_pkg::*;

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    // front: take bytes or code points, track the decode sequence, queue work
    utf8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push)
    );

    // hold pending work so each side can stall on its own
    utf8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // back: emit one result per transfer, advance through encode runs
    utf8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* bench/tb_utf8_transcoder.sv */
`timescale 1ns / 100ps

// Encode run lengths and UTF-8 lead/continuation tags.
localparam logic [20:0] ONE_BYTE_LIMIT   = 21'h00080;
localparam logic [20:0] TWO_BYTE_LIMIT   = 21'h00800;
localparam logic [20:0] THREE_BYTE_LIMIT = 21'h10000;
localparam logic [7:0]  LEAD2_TAG        = 8'hC0;
localparam logic [7:0]  LEAD3_TAG        = 8'hE0;
localparam logic [7:0]  LEAD4_TAG        = 8'hF0;
localparam logic [7:0]  CONT_TAG         = 8'h80;
localparam int          REPORT_LIMIT     = 10;

typedef struct packed {
    logic [utf8_pkg::CP_W-1:0] data;
    logic                      last;
} t_utf8_unit;

// Tracks direction and the partial decode, and queues the output units
// that each accepted input transfer must produce.
class transcode_tracker;
    logic                      dir;
    logic [utf8_pkg::CP_W-1:0] accum;
    logic [1:0]                bytes_left;
    t_utf8_unit                pending_units[$];
    int unsigned               mismatches;
    int unsigned               units_checked;

    function new();
        dir           = utf8_pkg::DIR_DECODE;
        accum         = '0;
        bytes_left    = '0;
        mismatches    = 0;
        units_checked = 0;
    endfunction

    function void write_direction(logic value);
        dir        = value;
        accum      = '0;
        bytes_left = '0;
    endfunction

    local function void queue_unit(logic [utf8_pkg::CP_W-1:0] value, logic is_last);
        t_utf8_unit u;
        u.data = value;
        u.last = is_last;
        pending_units.push_back(u);
    endfunction

    function void accept_item(logic [utf8_pkg::CP_W-1:0] d);
        logic [7:0] b;
        b = d[7:0];
        if (dir == utf8_pkg::DIR_ENCODE) begin
            if (d < ONE_BYTE_LIMIT) begin
                queue_unit(d, 1'b1);
            end else if (d < TWO_BYTE_LIMIT) begin
                queue_unit(21'(LEAD2_TAG | d[10:6]), 1'b0);
                queue_unit(21'(CONT_TAG | d[5:0]), 1'b1);
            end else if (d < THREE_BYTE_LIMIT) begin
                queue_unit(21'(LEAD3_TAG | d[15:12]), 1'b0);
                queue_unit(21'(CONT_TAG | d[11:6]), 1'b0);
                queue_unit(21'(CONT_TAG | d[5:0]), 1'b1);
            end else begin
                queue_unit(21'(LEAD4_TAG | d[20:18]), 1'b0);
                queue_unit(21'(CONT_TAG | d[17:12]), 1'b0);
                queue_unit(21'(CONT_TAG | d[11:6]), 1'b0);
                queue_unit(21'(CONT_TAG | d[5:0]), 1'b1);
            end
        end else if (bytes_left == 2'd0) begin
            if ((b & CONT_TAG) == 8'h00) begin
                queue_unit(21'(b), 1'b1);
            end else if ((b & LEAD3_TAG) == LEAD2_TAG) begin
                accum      = 21'(b[4:0]);
                bytes_left = 2'd1;
            end else if ((b & LEAD4_TAG) == LEAD3_TAG) begin
                accum      = 21'(b[3:0]);
                bytes_left = 2'd2;
            end else begin
                // anything else, stray continuations and 0xF8..0xFF too, opens four bytes
                accum      = 21'(b[2:0]);
                bytes_left = 2'd3;
            end
        end else begin
            accum      = {accum[14:0], b[5:0]};
            bytes_left = bytes_left - 2'd1;
            if (bytes_left == 2'd0) begin
                queue_unit(accum, 1'b1);
            end
        end
    endfunction

    function void match_unit(logic [utf8_pkg::CP_W-1:0] data, logic is_last);
        t_utf8_unit want;
        units_checked++;
        if (pending_units.size() == 0) begin
            if (mismatches < REPORT_LIMIT) begin
                $display("unexpected output unit: data_out=%h last=%b", data, is_last);
            end
            mismatches++;
        end else begin
            want = pending_units.pop_front();
            if (want.data !== data || want.last !== is_last) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("mismatch on unit %0d: expected data_out=%h last=%b, got %h %b",
                             units_checked, want.data, want.last, data, is_last);
                end
                mismatches++;
            end
        end
    endfunction

    function void flush_leftovers();
        if (pending_units.size() != 0) begin
            $display("%0d expected output units never arrived", pending_units.size());
            mismatches += pending_units.size();
            pending_units.delete();
        end
    endfunction
endclass

module tb_utf8_transcoder;
    import utf8_pkg::*;

    // Settle time after the last expected unit before touching direction.
    localparam int SETTLE_CYCLES  = 8;
    // Long output hold that fills the internal queue and backs up the input.
    localparam int HOLD_CYCLES    = 300;
    // Cycles with no transfer on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;

    utf8_in_if  in_if ();
    utf8_cfg_if cfg_if ();
    utf8_out_if out_if ();

    utf8_transcoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    transcode_tracker tracker;

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int unsigned items_sent;
    int unsigned decode_items;
    int unsigned encode_items;
    int unsigned dir_writes;
    int unsigned stall_cycles;

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random ready per cycle, with one long hold on request.
    // The hold is counted here so the sender keeps offering meanwhile.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Output monitor: every transfer is checked against the oldest
    // expected unit. Values sampled here are the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tracker.match_unit(out_if.data_out, out_if.last);
        end
    end

    // Watchdog: count cycles in which no channel moves a transfer.
    initial begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                    || (cfg_if.valid && cfg_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_utf8_transcoder: FAIL");
        $finish;
    end

    // Offer one input item and hold it until the transfer. Called right
    // after a rising edge; valid is either lowered for an idle gap or left
    // high, never both in one step.
    task automatic send_item(input logic [CP_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.data_in <= d;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        tracker.accept_item(d);
        items_sent++;
        if (tracker.dir == DIR_ENCODE) begin
            encode_items++;
        end else begin
            decode_items++;
        end
    endtask

    // Decode stimulus: mostly well-formed sequences with random payload,
    // the rest single random bytes (stray continuations, bad leads).
    // Bits 20..8 always carry junk that the block must ignore.
    task automatic send_decode_seq();
        logic [12:0] junk;
        logic [7:0]  lead;
        int          n_cont;
        if ($urandom_range(99) < 80) begin
            case ($urandom_range(3))
                0: begin lead = 8'($urandom_range(127));           n_cont = 0; end
                1: begin lead = LEAD2_TAG | 8'($urandom_range(31)); n_cont = 1; end
                2: begin lead = LEAD3_TAG | 8'($urandom_range(15)); n_cont = 2; end
                default: begin lead = LEAD4_TAG | 8'($urandom_range(7)); n_cont = 3; end
            endcase
            junk = 13'($urandom);
            send_item({junk, lead});
            repeat (n_cont) begin
                junk = 13'($urandom);
                send_item({junk, CONT_TAG | 8'($urandom_range(63))});
            end
        end else begin
            junk = 13'($urandom);
            send_item({junk, 8'($urandom_range(255))});
        end
    endtask

    // Encode stimulus: spread over every run length, beyond-Unicode values
    // and the full 21-bit range.
    task automatic send_code_point();
        logic [CP_W-1:0] cp;
        case ($urandom_range(5))
            0: cp = 21'($urandom_range(21'h7F));
            1: cp = 21'($urandom_range(21'h7FF, 21'h80));
            2: cp = 21'($urandom_range(21'hFFFF, 21'h800));
            3: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            4: cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
            default: cp = 21'($urandom);
        endcase
        send_item(cp);
    endtask

    // Drop valid and wait until every expected unit has arrived, then let
    // any partial decode settle.
    task automatic wait_quiet();
        in_if.valid <= 1'b0;
        while (tracker.pending_units.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the direction register; only called while the block is idle.
    task automatic write_direction(input logic value);
        cfg_if.valid     <= 1'b1;
        cfg_if.direction <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        tracker.write_direction(value);
        dir_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CP_W-1:0] decode_seed_bytes[16];
        logic [CP_W-1:0] encode_seed_points[8];

        tracker      = new();
        hold_req     = 1'b0;
        items_sent   = 0;
        decode_items = 0;
        encode_items = 0;
        dir_writes   = 0;
        tx_idle_pct  = 21;
        rx_idle_pct  = 60;

        // known values on every input from time zero
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_in    <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.direction <= DIR_DECODE;

        // directed decode: ASCII extremes, each sequence length, an invalid
        // 0xFF lead followed by bytes that are not continuations, and junk
        // in the upper bits
        decode_seed_bytes = '{21'h000000, 21'h00007F,
                              21'h0000C3, 21'h0000A9,
                              21'h0000E2, 21'h000082, 21'h0000AC,
                              21'h0000F0, 21'h00009F, 21'h000098, 21'h000080,
                              21'h0000FF, 21'h0000C2, 21'h000041, 21'h0000FF,
                              21'h1FFF41};
        // directed encode: both sides of every length boundary, the top of
        // Unicode and the top of the 21-bit range
        encode_seed_points = '{21'h00007F, 21'h000080, 21'h0007FF, 21'h000800,
                               21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h1FFFFF};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part, sender idles 21%, receiver 60% ---
        foreach (decode_seed_bytes[k]) send_item(decode_seed_bytes[k]);
        // leave a sequence half done; the direction write must abandon it
        send_item(21'h0000E2);
        send_item(21'h000082);
        wait_quiet();
        write_direction(DIR_DECODE);
        send_item(21'h000041);
        wait_quiet();
        write_direction(DIR_ENCODE);
        foreach (encode_seed_points[k]) send_item(encode_seed_points[k]);
        wait_quiet();
        write_direction(DIR_DECODE);

        // --- random decode, same idling ---
        while (items_sent < 110) send_decode_seq();

        // hold the output for a long stretch while ASCII keeps coming, so
        // the queue fills and the input stalls
        hold_req = 1'b1;
        repeat (20) send_item({13'($urandom), 1'b0, 7'($urandom_range(127))});

        // --- random encode, sender idles 60%, receiver 21% ---
        wait_quiet();
        tx_idle_pct = 60;
        rx_idle_pct = 21;
        write_direction(DIR_ENCODE);
        while (items_sent < 170) send_code_point();

        // --- no idling on either side, both directions ---
        wait_quiet();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_direction(DIR_DECODE);
        while (items_sent < 195) send_decode_seq();
        wait_quiet();
        write_direction(DIR_ENCODE);
        while (items_sent < 220) send_code_point();
        wait_quiet();

        tracker.flush_leftovers();
        $display("Run covered %0d decode bytes and %0d code points across %0d direction writes,",
                 decode_items, encode_items, dir_writes);
        $display("with %0d output units checked under three stall mixes and one %0d-cycle hold.",
                 tracker.units_checked, HOLD_CYCLES);
        if (tracker.mismatches == 0) begin
            $display("tb_utf8_transcoder: PASS");
        end else begin
            $display("%0d failures", tracker.mismatches);
            $display("tb_utf8_transcoder: FAIL");
        end
        $finish;
    end

endmodule
